[rtl/core/pcebd_pkg.sv]
// Package: shared constants, codes and the quadrature step table for the port change decoder.
package pcebd_pkg;

	localparam int unsigned PortW  = 8;
	localparam int unsigned PinW   = 3;
	localparam int unsigned PhaseW = 3;
	localparam int unsigned CountW = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 3;

	localparam logic [PortW-1:0] LatchReset = 8'hff;

	localparam logic [5:0] DirCwFlag  = 6'h10;
	localparam logic [5:0] DirCcwFlag = 6'h20;
	localparam logic [5:0] DirMask    = 6'h30;
	localparam logic [5:0] PhaseMask  = 6'h0f;

	localparam logic [PinW-1:0] EncPinOneReset = 3'd0;
	localparam logic [PinW-1:0] EncPinTwoReset = 3'd1;
	localparam logic [PinW-1:0] BtnPinReset    = 3'd2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ENC_ENABLE  = 3'd0,
		CFG_ENC_PIN_ONE = 3'd1,
		CFG_ENC_PIN_TWO = 3'd2,
		CFG_BTN_ENABLE  = 3'd3,
		CFG_BTN_PIN     = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		EVT_NONE = 2'd0,
		EVT_CW   = 2'd1,
		EVT_CCW  = 2'd2
	} step_event_t;

	// Full-step table: phase in bits [3:0], direction flag in bits [5:4].
	function automatic logic [5:0] quad_next(input logic [PhaseW-1:0] phase,
			input logic [1:0] pins);
		logic [5:0] r;
		r = 6'h00;
		case ({phase, pins})
			5'b000_00: r = 6'h00;
			5'b000_01: r = 6'h02;
			5'b000_10: r = 6'h04;
			5'b000_11: r = 6'h00;
			5'b001_00: r = 6'h03;
			5'b001_01: r = 6'h00;
			5'b001_10: r = 6'h01;
			5'b001_11: r = DirCwFlag;
			5'b010_00: r = 6'h03;
			5'b010_01: r = 6'h02;
			5'b010_10: r = 6'h00;
			5'b010_11: r = 6'h00;
			5'b011_00: r = 6'h03;
			5'b011_01: r = 6'h02;
			5'b011_10: r = 6'h01;
			5'b011_11: r = 6'h00;
			5'b100_00: r = 6'h06;
			5'b100_01: r = 6'h00;
			5'b100_10: r = 6'h04;
			5'b100_11: r = 6'h00;
			5'b101_00: r = 6'h06;
			5'b101_01: r = 6'h05;
			5'b101_10: r = 6'h00;
			5'b101_11: r = DirCcwFlag;
			5'b110_00: r = 6'h06;
			5'b110_01: r = 6'h05;
			5'b110_10: r = 6'h04;
			5'b110_11: r = 6'h00;
			5'b111_00: r = 6'h00;
			5'b111_01: r = 6'h02;
			5'b111_10: r = 6'h04;
			5'b111_11: r = 6'h00;
			default: r = 6'h00;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/port_change_encoder_button_decoder.sv]
// Top level: decodes captured port values into encoder steps and button state.
//
//  channel   dir  handshake             payload
//  in        in   in_valid / in_ready   port_value
//  out       out  out_valid / out_ready changed_bits, step_event, position_count,
//                                       button_level, button_changed
//  cfg       in   cfg_we                cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready stays high; a transaction passes
// the input register, then the result register. Decode, table step and count update
// happen in the same cycle. Reset clears the latch to all ones, the phase, count and
// button state. A stalled output holds the result; the input register still takes a
// transaction when the result register frees in the same cycle.
module port_change_encoder_button_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcebd_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [pcebd_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pcebd_pkg::PortW-1:0]         port_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pcebd_pkg::PortW-1:0]         changed_bits,
	output logic [1:0]                          step_event,
	output logic signed [pcebd_pkg::CountW-1:0] position_count,
	output logic                                button_level,
	output logic                                button_changed
);

	logic                          enc_en_q;
	logic [pcebd_pkg::PinW-1:0]    enc_pin1_q;
	logic [pcebd_pkg::PinW-1:0]    enc_pin2_q;
	logic                          btn_en_q;
	logic [pcebd_pkg::PinW-1:0]    btn_pin_q;

	logic [pcebd_pkg::PortW-1:0]   latch_q;
	logic [pcebd_pkg::PhaseW-1:0]  phase_q;
	logic [pcebd_pkg::CountW-1:0]  total_q;
	logic                          seen_q;
	logic                          flip_q;

	logic                          valid_s1;
	logic [pcebd_pkg::PortW-1:0]   port_s1;

	logic                          out_valid_q;
	logic [pcebd_pkg::PortW-1:0]   changed_q;
	logic [1:0]                    event_q;

	logic                          out_free;
	logic                          advance;
	logic [pcebd_pkg::PortW-1:0]   diff;
	logic [pcebd_pkg::PortW-1:0]   emask;
	logic [pcebd_pkg::PortW-1:0]   hit;
	logic [pcebd_pkg::PortW-1:0]   pending;
	logic                          enc_upd;
	logic                          btn_upd;
	logic [1:0]                    pins;
	logic [5:0]                    nxt;
	logic [1:0]                    evt;
	logic [pcebd_pkg::PhaseW-1:0]  phase_d;
	logic [pcebd_pkg::CountW-1:0]  total_d;
	logic                          lvl;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_comb begin
		diff    = port_s1 ^ latch_q;
		emask   = (8'b1 << enc_pin1_q) | (8'b1 << enc_pin2_q);
		hit     = emask & diff;
		enc_upd = enc_en_q && (hit != '0);
		pins    = {port_s1[enc_pin2_q], port_s1[enc_pin1_q]};
		nxt     = pcebd_pkg::quad_next(phase_q, pins);
		evt     = pcebd_pkg::EVT_NONE;
		phase_d = phase_q;
		total_d = total_q;
		pending = diff;
		if (enc_upd) begin
			phase_d = nxt[pcebd_pkg::PhaseW-1:0];
			pending = diff & ~hit;
			if ((nxt & pcebd_pkg::DirMask) == pcebd_pkg::DirCwFlag) begin
				total_d = total_q + 16'd1;
				evt     = pcebd_pkg::EVT_CW;
			end else if ((nxt & pcebd_pkg::DirMask) == pcebd_pkg::DirCcwFlag) begin
				total_d = total_q - 16'd1;
				evt     = pcebd_pkg::EVT_CCW;
			end
		end
		btn_upd = btn_en_q && pending[btn_pin_q];
		lvl     = port_s1[btn_pin_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_en_q   <= 1'b0;
			enc_pin1_q <= pcebd_pkg::EncPinOneReset;
			enc_pin2_q <= pcebd_pkg::EncPinTwoReset;
			btn_en_q   <= 1'b0;
			btn_pin_q  <= pcebd_pkg::BtnPinReset;
		end else if (cfg_we) begin
			case (cfg_index)
				pcebd_pkg::CFG_ENC_ENABLE:  enc_en_q   <= cfg_data[0];
				pcebd_pkg::CFG_ENC_PIN_ONE: enc_pin1_q <= cfg_data;
				pcebd_pkg::CFG_ENC_PIN_TWO: enc_pin2_q <= cfg_data;
				pcebd_pkg::CFG_BTN_ENABLE:  btn_en_q   <= cfg_data[0];
				pcebd_pkg::CFG_BTN_PIN:     btn_pin_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			latch_q     <= pcebd_pkg::LatchReset;
			phase_q     <= '0;
			total_q     <= '0;
			seen_q      <= 1'b0;
			flip_q      <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (out_free)
				out_valid_q <= valid_s1;
			if (advance) begin
				latch_q <= port_s1;
				phase_q <= phase_d;
				total_q <= total_d;
				if (btn_upd) begin
					flip_q <= (lvl != seen_q);
					seen_q <= lvl;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			port_s1 <= port_value;
		if (advance) begin
			changed_q <= diff;
			event_q   <= evt;
		end
	end

	assign out_valid      = out_valid_q;
	assign changed_bits   = changed_q;
	assign step_event     = event_q;
	assign position_count = total_q;
	assign button_level   = seen_q;
	assign button_changed = flip_q;

endmodule

[bench/tb_top.sv]
// Testbench for the port change decoder: predicts each result and checks it against the outputs.
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 88;

	typedef struct packed {
		logic [pcebd_pkg::PortW-1:0]         changed;
		pcebd_pkg::step_event_t              ev;
		logic signed [pcebd_pkg::CountW-1:0] count;
		logic                                level;
		logic                                flip;
	} decode_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_RUNS
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pcebd_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [pcebd_pkg::CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [pcebd_pkg::PortW-1:0] port_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pcebd_pkg::PortW-1:0] changed_bits;
	logic [1:0] step_event;
	logic signed [pcebd_pkg::CountW-1:0] position_count;
	logic button_level;
	logic button_changed;

	// register mirror
	logic enc_en = 1'b0;
	logic [pcebd_pkg::PinW-1:0] enc_p1 = pcebd_pkg::EncPinOneReset;
	logic [pcebd_pkg::PinW-1:0] enc_p2 = pcebd_pkg::EncPinTwoReset;
	logic btn_en = 1'b0;
	logic [pcebd_pkg::PinW-1:0] btn_p = pcebd_pkg::BtnPinReset;

	// decoder state
	logic [pcebd_pkg::PortW-1:0] mdl_latch = pcebd_pkg::LatchReset;
	logic [pcebd_pkg::PhaseW-1:0] mdl_phase = '0;
	logic [pcebd_pkg::CountW-1:0] mdl_count = '0;
	logic mdl_seen = 1'b0;
	logic mdl_flip = 1'b0;

	logic [pcebd_pkg::PortW-1:0] capture_q[$];
	decode_result_t pending_results[$];

	logic [pcebd_pkg::PortW-1:0] gen_val = pcebd_pkg::LatchReset;
	logic spin_cw = 1'b1;
	int err_cnt = 0;
	int cyc = 0;
	int gap_left = 0;
	int burst_left = 1;
	rx_mode_t rx_mode = RX_OPEN;
	logic [6:0] mode_cnt = '0;
	int run_left = 0;
	logic run_hi = 1'b0;

	port_change_encoder_button_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.port_value(port_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.changed_bits(changed_bits),
		.step_event(step_event),
		.position_count(position_count),
		.button_level(button_level),
		.button_changed(button_changed)
	);

	always #4 clk = ~clk;

	// full-step table row per phase, entry per pin state {two, one}
	function automatic logic [5:0] enc_next(input logic [pcebd_pkg::PhaseW-1:0] phase,
			input logic [1:0] pins);
		logic [23:0] row;
		case (phase)
			3'd1: row = {6'h10, 6'h01, 6'h00, 6'h03};
			3'd2: row = {6'h00, 6'h00, 6'h02, 6'h03};
			3'd3: row = {6'h00, 6'h01, 6'h02, 6'h03};
			3'd4: row = {6'h00, 6'h04, 6'h00, 6'h06};
			3'd5: row = {6'h20, 6'h00, 6'h05, 6'h06};
			3'd6: row = {6'h00, 6'h04, 6'h05, 6'h06};
			default: row = {6'h00, 6'h04, 6'h02, 6'h00};
		endcase
		return row[pins*6 +: 6];
	endfunction

	task automatic decode_capture(input logic [pcebd_pkg::PortW-1:0] now);
		logic [pcebd_pkg::PortW-1:0] diff;
		logic [pcebd_pkg::PortW-1:0] open_bits;
		logic [pcebd_pkg::PortW-1:0] hit;
		logic [5:0] nxt;
		decode_result_t res;
		diff = now ^ mdl_latch;
		open_bits = diff;
		res.ev = pcebd_pkg::EVT_NONE;
		if (open_bits != 0 && enc_en) begin
			hit = ((8'd1 << enc_p1) | (8'd1 << enc_p2)) & open_bits;
			if (hit != 0) begin
				nxt = enc_next(mdl_phase, {now[enc_p2], now[enc_p1]});
				mdl_phase = nxt[pcebd_pkg::PhaseW-1:0];
				if ((nxt & pcebd_pkg::DirMask) == pcebd_pkg::DirCwFlag) begin
					mdl_count = mdl_count + 1'b1;
					res.ev = pcebd_pkg::EVT_CW;
				end else if ((nxt & pcebd_pkg::DirMask) == pcebd_pkg::DirCcwFlag) begin
					mdl_count = mdl_count - 1'b1;
					res.ev = pcebd_pkg::EVT_CCW;
				end
				open_bits = open_bits & ~hit;
			end
		end
		if (open_bits != 0 && btn_en && open_bits[btn_p]) begin
			mdl_flip = (now[btn_p] != mdl_seen);
			mdl_seen = now[btn_p];
		end
		mdl_latch = now;
		res.changed = diff;
		res.count = mdl_count;
		res.level = mdl_seen;
		res.flip = mdl_flip;
		pending_results.push_back(res);
	endtask

	// mostly gray-code walks on the encoder pins while it is enabled, plus button presses and noise
	function automatic logic [pcebd_pkg::PortW-1:0] next_stim();
		logic [pcebd_pkg::PortW-1:0] v;
		logic [1:0] ps;
		int r;
		int b;
		v = gen_val;
		r = $urandom_range(0, 99);
		b = $urandom_range(0, 7);
		if (enc_en && r < 60) begin
			if ($urandom_range(0, 9) == 0)
				spin_cw = !spin_cw;
			ps = {v[enc_p2], v[enc_p1]};
			if ((ps == 2'b11 || ps == 2'b00) == spin_cw)
				v[enc_p2] = !v[enc_p2];
			else
				v[enc_p1] = !v[enc_p1];
		end else if (r < 75) begin
			v[btn_p] = !v[btn_p];
		end else if (r < 85) begin
			v[b] = !v[b];
		end else if (r < 93) begin
			v = 8'($urandom_range(0, 255));
		end
		gen_val = v;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cyc, what, got, want);
		err_cnt++;
	endtask

	task automatic set_reg(input logic [pcebd_pkg::CfgIdxW-1:0] idx,
			input logic [pcebd_pkg::CfgDataW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			pcebd_pkg::CFG_ENC_ENABLE: enc_en = data[0];
			pcebd_pkg::CFG_ENC_PIN_ONE: enc_p1 = data;
			pcebd_pkg::CFG_ENC_PIN_TWO: enc_p2 = data;
			pcebd_pkg::CFG_BTN_ENABLE: btn_en = data[0];
			pcebd_pkg::CFG_BTN_PIN: btn_p = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (capture_q.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				decode_capture(port_value);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (capture_q.size() != 0) begin
					port_value <= capture_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin : rx_side
		logic nr;
		decode_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected transaction, changed_bits",
						16'(changed_bits), 16'd0);
				end else begin
					want = pending_results.pop_front();
					if (changed_bits !== want.changed)
						report_mismatch("changed_bits", 16'(changed_bits), 16'(want.changed));
					if (step_event !== want.ev)
						report_mismatch("step_event", 16'(step_event), 16'(want.ev));
					if (position_count !== want.count)
						report_mismatch("position_count", position_count, want.count);
					if (button_level !== want.level)
						report_mismatch("button_level", 16'(button_level), 16'(want.level));
					if (button_changed !== want.flip)
						report_mismatch("button_changed", 16'(button_changed), 16'(want.flip));
				end
			end
			mode_cnt = mode_cnt + 1'b1;
			if (mode_cnt == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN: nr = 1'b1;
				RX_COIN: nr = 1'($urandom_range(0, 1));
				RX_SPARSE: nr = (mode_cnt[1:0] == 2'b00);
				default: begin
					if (run_left == 0) begin
						run_hi = !run_hi;
						run_left = $urandom_range(1, 30);
					end
					run_left--;
					nr = run_hi;
				end
			endcase
			out_ready <= nr;
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [pcebd_pkg::CfgDataW-1:0] d;
		logic [pcebd_pkg::PinW-1:0] p;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: nothing enabled, first capture equals the latch
		capture_q.push_back(8'hff); capture_q.push_back(8'h00); capture_q.push_back(8'hff);
		drain();

		set_reg(pcebd_pkg::CFG_ENC_ENABLE, 3'd1);
		set_reg(pcebd_pkg::CFG_ENC_PIN_ONE, 3'd0);
		set_reg(pcebd_pkg::CFG_ENC_PIN_TWO, 3'd1);
		set_reg(pcebd_pkg::CFG_BTN_ENABLE, 3'd1);
		set_reg(pcebd_pkg::CFG_BTN_PIN, 3'd2);
		// indexes past the last register must be ignored
		for (int i = int'(pcebd_pkg::CFG_BTN_PIN) + 1; i < (1 << pcebd_pkg::CfgIdxW); i++)
			set_reg(pcebd_pkg::CfgIdxW'(i), 3'd7);
		// button low on first edge, one step each way, presses
		capture_q.push_back(8'hfb);
		capture_q.push_back(8'hf9); capture_q.push_back(8'hf8);
		capture_q.push_back(8'hfa); capture_q.push_back(8'hfb);
		capture_q.push_back(8'hfa); capture_q.push_back(8'hf8);
		capture_q.push_back(8'hf9); capture_q.push_back(8'hfb);
		capture_q.push_back(8'hff); capture_q.push_back(8'hfb);
		capture_q.push_back(8'h7b); capture_q.push_back(8'h7b);
		drain();

		// both encoder lines and the button on one pin
		set_reg(pcebd_pkg::CFG_ENC_PIN_ONE, 3'd3);
		set_reg(pcebd_pkg::CFG_ENC_PIN_TWO, 3'd3);
		set_reg(pcebd_pkg::CFG_BTN_PIN, 3'd3);
		capture_q.push_back(8'h00); capture_q.push_back(8'h08); capture_q.push_back(8'h00);
		drain();
		set_reg(pcebd_pkg::CFG_BTN_PIN, 3'd0);
		capture_q.push_back(8'h09); capture_q.push_back(8'h00);
		drain();

		// top and bottom pins, button shared with line one
		set_reg(pcebd_pkg::CFG_ENC_PIN_ONE, 3'd7);
		set_reg(pcebd_pkg::CFG_ENC_PIN_TWO, 3'd0);
		set_reg(pcebd_pkg::CFG_BTN_PIN, 3'd7);
		capture_q.push_back(8'h81); capture_q.push_back(8'h80);
		capture_q.push_back(8'h00); capture_q.push_back(8'h01); capture_q.push_back(8'h81);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			d = pcebd_pkg::CfgDataW'($urandom_range(0, 7));
			if (ph != 1 && $urandom_range(0, 4) != 0)
				d[0] = 1'b1;
			set_reg(pcebd_pkg::CFG_ENC_ENABLE, d);
			p = pcebd_pkg::PinW'($urandom_range(0, 7));
			set_reg(pcebd_pkg::CFG_ENC_PIN_ONE, p);
			if ($urandom_range(0, 7) != 0)
				p = pcebd_pkg::PinW'($urandom_range(0, 7));
			set_reg(pcebd_pkg::CFG_ENC_PIN_TWO, p);
			d = pcebd_pkg::CfgDataW'($urandom_range(0, 7));
			if (ph != 1 && $urandom_range(0, 3) != 0)
				d[0] = 1'b1;
			set_reg(pcebd_pkg::CFG_BTN_ENABLE, d);
			set_reg(pcebd_pkg::CFG_BTN_PIN, pcebd_pkg::PinW'($urandom_range(0, 7)));
			gen_val = mdl_latch;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				capture_q.push_back(next_stim());
			drain();
		end

		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
